// ----- design/cda_pkg.sv -----
// ----------------------------------------------------------------------------
// cda_pkg
// Types, constants and calendar helpers shared by the date adjuster modules.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam int YEAR_W    = 16;
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int DIV_W     = 16;
    localparam int DVSR_W    = 9;

    localparam logic [DVSR_W-1:0] DIVISOR_YEAR  = DVSR_W'(400);
    localparam logic [DVSR_W-1:0] DIVISOR_MONTH = DVSR_W'(12);

    // Division by 12 is a shift by two and a multiply by a reciprocal of 3;
    // division by 400 is a shift by four and a multiply by a reciprocal of 25.
    localparam int SCALE_W        = 14;
    localparam int RECIP_W        = 15;
    localparam int PROD_W         = SCALE_W + RECIP_W;
    localparam int PRE_SH_MONTH   = 2;
    localparam int PRE_SH_YEAR    = 4;
    localparam int RECIP_SH_MONTH = 16;
    localparam int RECIP_SH_YEAR  = 17;
    localparam logic [RECIP_W-1:0] RECIP_MONTH = RECIP_W'(21846);
    localparam logic [RECIP_W-1:0] RECIP_YEAR  = RECIP_W'(5243);

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_LEAP  = DAY_W'(29);
    localparam logic [DAY_W-1:0]   DAY_FEB_COMMON = DAY_W'(28);

    localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
        DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
        DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
    };

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_DAYS   = 2'd1,
        CMD_MONTHS = 2'd2,
        CMD_YEARS  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DVSR_W-1:0] remainder;
    } div_rsp_t;

    // The remainder of the year modulo 400 settles all three leap tests.
    function automatic logic leap_from_rem(input logic [DVSR_W-1:0] rem);
        return (rem[1:0] == 2'b00) && (rem != DVSR_W'(100)) &&
               (rem != DVSR_W'(200)) && (rem != DVSR_W'(300));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        n = '0;
        if (month >= MONTH_JAN && month <= MONTH_DEC) begin
            n = MONTH_DAYS[4'(month - MONTH_JAN)];
            if (month == MONTH_FEB && leap) begin
                n = n + DAY_W'(1);
            end
        end
        return n;
    endfunction

endpackage

// ----- design/cda_divider.sv -----
// ----------------------------------------------------------------------------
// cda_divider
// Divides an unsigned word by the month or the year divisor through a
// reciprocal multiplication, quotient first and then remainder. Serves the
// leap-year test and the month carry.
// ----------------------------------------------------------------------------
module cda_divider
    import cda_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                phase_reg, phase_next;
    logic [DIV_W-1:0]    num_reg, num_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DVSR_W-1:0]   rem_reg, rem_next;
    logic [DVSR_W-1:0]   dvsr_reg, dvsr_next;
    logic                by_month;
    logic [SCALE_W-1:0]  scaled;
    logic [RECIP_W-1:0]  recip;
    logic [PROD_W-1:0]   prod;
    logic [DIV_W-1:0]    back;

    assign by_month = (dvsr_reg == DIVISOR_MONTH);
    assign scaled   = by_month ? SCALE_W'(num_reg >> PRE_SH_MONTH)
                               : SCALE_W'(num_reg >> PRE_SH_YEAR);
    assign recip    = by_month ? RECIP_MONTH : RECIP_YEAR;
    assign prod     = PROD_W'(scaled) * PROD_W'(recip);
    assign back     = quo_reg * DIV_W'(dvsr_reg);

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvsr_next  = dvsr_reg;
        if (req.start) begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            num_next   = req.dividend;
            dvsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                quo_next   = by_month ? DIV_W'(prod >> RECIP_SH_MONTH)
                                      : DIV_W'(prod >> RECIP_SH_YEAR);
                phase_next = 1'b1;
            end else begin
                rem_next  = DVSR_W'(num_reg - back);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        phase_reg <= phase_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvsr_reg  <= dvsr_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- design/calendar_date_adjuster_unit.sv -----
// ----------------------------------------------------------------------------
// calendar_date_adjuster_unit
// Holds one Gregorian date and applies one load or add command per item,
// answering with the date, its leap flags and its validity.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    cmd, amount, load date fields
//  m_        out        m_valid / m_ready    date, leap_year, leap_day, date_valid
//
// A load and a year add each wait on one division by 400 in the reciprocal
// divider, a month add on a division by 12 and then one by 400. A day add
// steps one day at a time and divides again at each year boundary crossed.
// Reset gives January 1, 2000. s_ready is high only while the sequencer is
// idle; a finished result waits in the output register while the next item
// is already being worked.
module calendar_date_adjuster_unit
    import cda_pkg::*;
#(
    parameter int AMOUNT_BITS = 11
)
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic signed [AMOUNT_BITS-1:0] s_amount,
    input  logic [DAY_W-1:0]              s_load_day,
    input  logic [MONTH_W-1:0]            s_load_month,
    input  logic [YEAR_W-1:0]             s_load_year,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [DAY_W-1:0]              m_day_out,
    output logic [MONTH_W-1:0]            m_month_out,
    output logic [YEAR_W-1:0]             m_year_out,
    output logic                          m_leap_year,
    output logic                          m_leap_day,
    output logic                          m_date_valid
);

    localparam int TOT_W = AMOUNT_BITS + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAYS,
        S_LEAP,
        S_MDIV,
        S_CLAMP,
        S_YDIV,
        S_FIN
    } state_t;

    state_t                   state_reg, state_next;
    state_t                   after_reg, after_next;
    logic [DAY_W-1:0]         day_reg, day_next;
    logic [MONTH_W-1:0]       month_reg, month_next;
    logic [YEAR_W-1:0]        year_reg, year_next;
    logic                     leap_reg, leap_next;
    logic [AMOUNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                     fwd_reg, fwd_next;
    logic                     neg_reg, neg_next;
    logic [YEAR_W-1:0]        tmp_year_reg, tmp_year_next;
    logic                     m_valid_reg, m_valid_next;
    logic [DAY_W-1:0]         o_day_reg, o_day_next;
    logic [MONTH_W-1:0]       o_month_reg, o_month_next;
    logic [YEAR_W-1:0]        o_year_reg, o_year_next;
    logic                     o_leap_reg, o_leap_next;
    logic                     o_lday_reg, o_lday_next;
    logic                     o_ok_reg, o_ok_next;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic [DAY_W-1:0]         cur_len;
    logic                     date_ok;
    logic [AMOUNT_BITS-1:0]   mag;
    logic signed [TOT_W-1:0]  total;
    logic [YEAR_W-1:0]        new_year;
    logic [YEAR_W-1:0]        carry_year;
    logic [MONTH_W-1:0]       rem_month;
    logic                     rem_leap;

    cda_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cur_len  = month_len(month_reg, leap_reg);
    assign date_ok  = (cur_len != '0) && (day_reg != '0) && (day_reg <= cur_len);
    assign mag      = s_amount[AMOUNT_BITS-1] ? AMOUNT_BITS'(-s_amount)
                                              : AMOUNT_BITS'(s_amount);
    assign total    = TOT_W'($signed({1'b0, month_reg})) - TOT_W'(1) + TOT_W'(s_amount);
    assign new_year = year_reg + YEAR_W'(s_amount);
    assign carry_year = year_reg + (neg_reg ? ~div_rsp.quotient : div_rsp.quotient);
    assign rem_month  = MONTH_W'(div_rsp.remainder);
    assign rem_leap   = leap_from_rem(div_rsp.remainder);
    assign s_ready    = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        after_next    = after_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        leap_next     = leap_reg;
        cnt_next      = cnt_reg;
        fwd_next      = fwd_reg;
        neg_next      = neg_reg;
        tmp_year_next = tmp_year_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        o_day_next    = o_day_reg;
        o_month_next  = o_month_reg;
        o_year_next   = o_year_reg;
        o_leap_next   = o_leap_reg;
        o_lday_next   = o_lday_reg;
        o_ok_next     = o_ok_reg;
        div_req       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (cmd_t'(s_cmd) == CMD_LOAD) begin
                        day_next         = s_load_day;
                        month_next       = s_load_month;
                        year_next        = s_load_year;
                        div_req.start    = 1'b1;
                        div_req.dividend = s_load_year;
                        div_req.divisor  = DIVISOR_YEAR;
                        after_next       = S_FIN;
                        state_next       = S_LEAP;
                    end else if (!date_ok || s_amount == '0) begin
                        state_next = S_FIN;
                    end else begin
                        case (cmd_t'(s_cmd))
                            CMD_DAYS: begin
                                fwd_next   = !s_amount[AMOUNT_BITS-1];
                                cnt_next   = mag;
                                state_next = S_DAYS;
                            end
                            CMD_MONTHS: begin
                                neg_next         = total[TOT_W-1];
                                div_req.start    = 1'b1;
                                div_req.dividend = total[TOT_W-1] ? DIV_W'(~total)
                                                                  : DIV_W'(total);
                                div_req.divisor  = DIVISOR_MONTH;
                                state_next       = S_MDIV;
                            end
                            default: begin
                                tmp_year_next    = new_year;
                                div_req.start    = 1'b1;
                                div_req.dividend = new_year;
                                div_req.divisor  = DIVISOR_YEAR;
                                state_next       = S_YDIV;
                            end
                        endcase
                    end
                end
            end
            S_DAYS: begin
                if (cnt_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    cnt_next = cnt_reg - AMOUNT_BITS'(1);
                    if (fwd_reg) begin
                        if (day_reg < cur_len) begin
                            day_next = day_reg + DAY_W'(1);
                        end else begin
                            day_next = DAY_W'(1);
                            if (month_reg == MONTH_DEC) begin
                                month_next       = MONTH_JAN;
                                year_next        = year_reg + YEAR_W'(1);
                                div_req.start    = 1'b1;
                                div_req.dividend = year_reg + YEAR_W'(1);
                                div_req.divisor  = DIVISOR_YEAR;
                                after_next       = S_DAYS;
                                state_next       = S_LEAP;
                            end else begin
                                month_next = month_reg + MONTH_W'(1);
                            end
                        end
                    end else begin
                        if (day_reg <= DAY_W'(1)) begin
                            if (month_reg <= MONTH_JAN) begin
                                month_next       = MONTH_DEC;
                                day_next         = MONTH_DAYS[11];
                                year_next        = year_reg - YEAR_W'(1);
                                div_req.start    = 1'b1;
                                div_req.dividend = year_reg - YEAR_W'(1);
                                div_req.divisor  = DIVISOR_YEAR;
                                after_next       = S_DAYS;
                                state_next       = S_LEAP;
                            end else begin
                                month_next = month_reg - MONTH_W'(1);
                                day_next   = month_len(month_reg - MONTH_W'(1), leap_reg);
                            end
                        end else begin
                            day_next = day_reg - DAY_W'(1);
                        end
                    end
                end
            end
            S_LEAP: begin
                if (div_rsp.done) begin
                    leap_next  = rem_leap;
                    state_next = after_reg;
                end
            end
            S_MDIV: begin
                if (div_rsp.done) begin
                    month_next       = neg_reg ? MONTH_DEC - rem_month
                                               : rem_month + MONTH_W'(1);
                    year_next        = carry_year;
                    div_req.start    = 1'b1;
                    div_req.dividend = carry_year;
                    div_req.divisor  = DIVISOR_YEAR;
                    after_next       = S_CLAMP;
                    state_next       = S_LEAP;
                end
            end
            S_CLAMP: begin
                if (day_reg > cur_len) begin
                    day_next = cur_len;
                end
                state_next = S_FIN;
            end
            S_YDIV: begin
                if (div_rsp.done) begin
                    if (month_reg == MONTH_FEB && day_reg == DAY_LEAP && leap_reg &&
                        !rem_leap) begin
                        day_next = DAY_FEB_COMMON;
                    end
                    year_next  = tmp_year_reg;
                    leap_next  = rem_leap;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_day_next   = day_reg;
                    o_month_next = month_reg;
                    o_year_next  = year_reg;
                    o_leap_next  = leap_reg;
                    o_lday_next  = (day_reg == DAY_LEAP) && (month_reg == MONTH_FEB) &&
                                   leap_reg;
                    o_ok_next    = date_ok;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            after_reg   <= S_FIN;
            day_reg     <= DAY_W'(1);
            month_reg   <= MONTH_JAN;
            year_reg    <= YEAR_W'(2000);
            leap_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            after_reg   <= after_next;
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
            leap_reg    <= leap_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg      <= cnt_next;
        fwd_reg      <= fwd_next;
        neg_reg      <= neg_next;
        tmp_year_reg <= tmp_year_next;
        o_day_reg    <= o_day_next;
        o_month_reg  <= o_month_next;
        o_year_reg   <= o_year_next;
        o_leap_reg   <= o_leap_next;
        o_lday_reg   <= o_lday_next;
        o_ok_reg     <= o_ok_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_day_out    = o_day_reg;
    assign m_month_out  = o_month_reg;
    assign m_year_out   = o_year_reg;
    assign m_leap_year  = o_leap_reg;
    assign m_leap_day   = o_lday_reg;
    assign m_date_valid = o_ok_reg;

    a_days_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DAYS |-> date_ok)
        else $error("Day stepping reached an invalid date.");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("Divider started while busy.");

    a_leap_day: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_leap_day |-> m_leap_year && m_month_out == MONTH_FEB &&
                                  m_day_out == DAY_LEAP && m_date_valid)
        else $error("Leap day flag without February 29 of a leap year.");

    a_wait_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LEAP || state_reg == S_MDIV || state_reg == S_YDIV) &&
        !div_rsp.done |-> div_rsp.busy)
        else $error("Sequencer waits on an idle divider.");

endmodule

// ----- tb/sv/calendar_date_adjuster_checker.sv -----
// ----------------------------------------------------------------------------
// calendar_date_adjuster_checker
// Watches both channels of the date adjuster. It keeps its own calendar
// state, works out the date and flags that each accepted command must give,
// and compares every result item against the oldest pending date.
// ----------------------------------------------------------------------------
module calendar_date_adjuster_checker
    import cda_pkg::*;
#(
    parameter int AMT_W = 11
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [1:0]              s_cmd,
    input  logic signed [AMT_W-1:0] s_amount,
    input  logic [DAY_W-1:0]        s_load_day,
    input  logic [MONTH_W-1:0]      s_load_month,
    input  logic [YEAR_W-1:0]       s_load_year,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [DAY_W-1:0]        m_day_out,
    input  logic [MONTH_W-1:0]      m_month_out,
    input  logic [YEAR_W-1:0]       m_year_out,
    input  logic                    m_leap_year,
    input  logic                    m_leap_day,
    input  logic                    m_date_valid,
    output int                      fail_count,
    output int                      outstanding,
    output int                      checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               leap_year;
        logic               leap_day;
        logic               valid;
    } date_result_t;

    date_result_t       pending_dates[$];
    logic [DAY_W-1:0]   cal_day;
    logic [MONTH_W-1:0] cal_month;
    logic [YEAR_W-1:0]  cal_year;
    int                 n_fail = 0;
    int                 n_checked = 0;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y);
        case (m)
            4'd2: return is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic calendar_is_real();
        logic [DAY_W-1:0] n;
        n = days_in(cal_month, cal_year);
        return (n != 0) && (cal_day >= 1) && (cal_day <= n);
    endfunction

    task automatic step_day_forward();
        if (cal_day < days_in(cal_month, cal_year)) begin
            cal_day = cal_day + 1'b1;
        end else begin
            cal_day = 5'd1;
            if (cal_month >= 4'd12) begin
                cal_month = 4'd1;
                cal_year  = cal_year + 1'b1;
            end else begin
                cal_month = cal_month + 1'b1;
            end
        end
    endtask

    task automatic step_day_backward();
        if (cal_day <= 5'd1) begin
            if (cal_month <= 4'd1) begin
                cal_month = 4'd12;
                cal_year  = cal_year - 1'b1;
            end else begin
                cal_month = cal_month - 1'b1;
            end
            cal_day = days_in(cal_month, cal_year);
        end else begin
            cal_day = cal_day - 1'b1;
        end
    endtask

    task automatic apply_command(input cmd_t c, input int k,
                                 input logic [DAY_W-1:0] ld,
                                 input logic [MONTH_W-1:0] lm,
                                 input logic [YEAR_W-1:0] ly);
        int                total;
        int                dy;
        int                dm;
        logic [YEAR_W-1:0] ny;
        if (c == CMD_LOAD) begin
            cal_day   = ld;
            cal_month = lm;
            cal_year  = ly;
        end else if (calendar_is_real() && k != 0) begin
            case (c)
                CMD_DAYS: begin
                    if (k > 0) begin
                        for (int i = 0; i < k; i++) step_day_forward();
                    end else begin
                        for (int i = 0; i > k; i--) step_day_backward();
                    end
                end
                CMD_MONTHS: begin
                    total = int'(cal_month) - 1 + k;
                    dy = total / 12;
                    dm = total % 12;
                    if (dm < 0) begin
                        dm = dm + 12;
                        dy = dy - 1;
                    end
                    cal_month = MONTH_W'(dm + 1);
                    cal_year  = cal_year + YEAR_W'(dy);
                    if (cal_day > days_in(cal_month, cal_year)) begin
                        cal_day = days_in(cal_month, cal_year);
                    end
                end
                CMD_YEARS: begin
                    ny = cal_year + YEAR_W'(k);
                    if (cal_month == 4'd2 && cal_day == 5'd29 && is_leap(cal_year) &&
                        !is_leap(ny)) begin
                        cal_day = 5'd28;
                    end
                    cal_year = ny;
                end
                default: begin
                end
            endcase
        end
    endtask

    function automatic date_result_t current_date();
        date_result_t r;
        r.day       = cal_day;
        r.month     = cal_month;
        r.year      = cal_year;
        r.leap_year = is_leap(cal_year);
        r.leap_day  = (cal_day == 5'd29) && (cal_month == 4'd2) && is_leap(cal_year);
        r.valid     = calendar_is_real();
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge aclk) begin : watch
        date_result_t want;
        if (!aresetn) begin
            cal_day   = 5'd1;
            cal_month = 4'd1;
            cal_year  = 16'd2000;
            pending_dates.delete();
        end else begin
            if (s_valid && s_ready) begin
                apply_command(cmd_t'(s_cmd), int'(s_amount), s_load_day, s_load_month,
                              s_load_year);
                pending_dates.push_back(current_date());
            end
            if (m_valid && m_ready) begin
                if (pending_dates.size() == 0) begin
                    $error("result item %0d-%0d-%0d arrived with no date pending",
                           m_year_out, m_month_out, m_day_out);
                    n_fail++;
                end else begin
                    want = pending_dates.pop_front();
                    check_field("day_out", want.day, m_day_out);
                    check_field("month_out", want.month, m_month_out);
                    check_field("year_out", want.year, m_year_out);
                    check_field("leap_year", want.leap_year, m_leap_year);
                    check_field("leap_day", want.leap_day, m_leap_day);
                    check_field("date_valid", want.valid, m_date_valid);
                    n_checked++;
                end
            end
        end
        fail_count    <= n_fail;
        outstanding   <= pending_dates.size();
        checked_count <= n_checked;
    end

endmodule

// ----- tb/sv/calendar_date_adjuster_unit_tb.sv -----
// ----------------------------------------------------------------------------
// calendar_date_adjuster_unit_tb
// Drives load and add commands into the date adjuster: a directed set around
// leap days, month and year ends, year wrap, amount extremes and invalid
// dates, then random load-and-adjust sequences mixed with noise. The sender
// works in bursts and the receiver stalls; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module calendar_date_adjuster_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cda_pkg::*;

    localparam int AMT_W = 11;
    localparam int ITEMS = 580;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [1:0]              s_cmd;
    logic signed [AMT_W-1:0] s_amount;
    logic [DAY_W-1:0]        s_load_day;
    logic [MONTH_W-1:0]      s_load_month;
    logic [YEAR_W-1:0]       s_load_year;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [DAY_W-1:0]        m_day_out;
    logic [MONTH_W-1:0]      m_month_out;
    logic [YEAR_W-1:0]       m_year_out;
    logic                    m_leap_year;
    logic                    m_leap_day;
    logic                    m_date_valid;

    int       fail_count;
    int       outstanding;
    int       checked_count;
    int       burst_left = 0;
    int       n_sent = 0;
    int       cmd_seen[4] = '{0, 0, 0, 0};
    rx_mode_t rx_mode = RX_FREE;
    int       rx_left = 0;
    int       rx_tick = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    calendar_date_adjuster_unit #(.AMOUNT_BITS(AMT_W)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_amount(s_amount),
        .s_load_day(s_load_day), .s_load_month(s_load_month), .s_load_year(s_load_year),
        .m_valid(m_valid), .m_ready(m_ready), .m_day_out(m_day_out),
        .m_month_out(m_month_out), .m_year_out(m_year_out), .m_leap_year(m_leap_year),
        .m_leap_day(m_leap_day), .m_date_valid(m_date_valid)
    );

    calendar_date_adjuster_checker #(.AMT_W(AMT_W)) date_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_amount(s_amount),
        .s_load_day(s_load_day), .s_load_month(s_load_month), .s_load_year(s_load_year),
        .m_valid(m_valid), .m_ready(m_ready), .m_day_out(m_day_out),
        .m_month_out(m_month_out), .m_year_out(m_year_out), .m_leap_year(m_leap_year),
        .m_leap_day(m_leap_day), .m_date_valid(m_date_valid),
        .fail_count(fail_count), .outstanding(outstanding), .checked_count(checked_count)
    );

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 120);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_FREE:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:   m_ready <= (rx_tick % 4 != 0);
        endcase
    end

    function automatic int last_day(input int m, input int y);
        case (m)
            2: return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic int pick_amount();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return ($urandom_range(0, 1) != 0) ? 1023 : -1024;
            2, 3, 4: return int'($urandom_range(0, 2047)) - 1024;
            default: return int'($urandom_range(0, 60)) - 30;
        endcase
    endfunction

    // Called right after a rising edge; returns at the edge that accepts the item.
    task automatic issue(input cmd_t c, input int amt, input int d, input int m,
                         input int y);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid      <= 1'b1;
        s_cmd        <= c;
        s_amount     <= AMT_W'(amt);
        s_load_day   <= DAY_W'(d);
        s_load_month <= MONTH_W'(m);
        s_load_year  <= YEAR_W'(y);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        n_sent++;
        cmd_seen[c]++;
    endtask

    task automatic random_valid_load();
        int y;
        int m;
        int d;
        case ($urandom_range(0, 3))
            0: y = $urandom_range(0, 65535);
            1: y = 100 * $urandom_range(0, 655);
            2: y = ($urandom_range(0, 1) != 0) ? $urandom_range(65530, 65535)
                                               : $urandom_range(0, 5);
            default: y = $urandom_range(1896, 2104);
        endcase
        m = $urandom_range(1, 12);
        if ($urandom_range(0, 7) == 0) begin
            m = 2;
            d = last_day(m, y);
        end else if ($urandom_range(0, 1) != 0) begin
            d = last_day(m, y) - $urandom_range(0, 1);
        end else begin
            d = $urandom_range(1, last_day(m, y));
        end
        issue(CMD_LOAD, int'($urandom_range(0, 2047)), d, m, y);
    endtask

    task automatic random_add();
        issue(cmd_t'(2'($urandom_range(1, 3))), pick_amount(), $urandom_range(0, 31),
              $urandom_range(0, 15), $urandom_range(0, 65535));
    endtask

    initial begin
        int n_directed;
        s_valid      <= 1'b0;
        s_cmd        <= CMD_LOAD;
        s_amount     <= '0;
        s_load_day   <= '0;
        s_load_month <= '0;
        s_load_year  <= '0;
        aresetn      <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        issue(CMD_DAYS, 0, 0, 0, 0);
        issue(CMD_LOAD, 0, 28, 2, 2000);
        issue(CMD_DAYS, 1, 0, 0, 0);
        issue(CMD_DAYS, 1, 0, 0, 0);
        issue(CMD_DAYS, -1, 0, 0, 0);
        issue(CMD_YEARS, 1, 0, 0, 0);
        issue(CMD_LOAD, 0, 28, 2, 1900);
        issue(CMD_DAYS, 1, 0, 0, 0);
        issue(CMD_LOAD, 0, 29, 2, 2400);
        issue(CMD_YEARS, -1024, 0, 0, 0);
        issue(CMD_LOAD, -1, 31, 12, 65535);
        issue(CMD_DAYS, 1, 31, 15, 65535);
        issue(CMD_DAYS, -1, 0, 0, 0);
        issue(CMD_DAYS, 1023, 0, 0, 0);
        issue(CMD_DAYS, -1024, 0, 0, 0);
        issue(CMD_LOAD, 0, 31, 1, 2001);
        issue(CMD_MONTHS, 1, 0, 0, 0);
        issue(CMD_LOAD, 0, 30, 11, 2000);
        issue(CMD_MONTHS, 1, 0, 0, 0);
        issue(CMD_MONTHS, -1024, 0, 0, 0);
        issue(CMD_MONTHS, 1023, 0, 0, 0);
        issue(CMD_YEARS, 1023, 0, 0, 0);
        issue(CMD_LOAD, 0, 0, 0, 2000);
        issue(CMD_DAYS, 5, 0, 0, 0);
        issue(CMD_LOAD, 0, 31, 15, 65535);
        issue(CMD_MONTHS, -3, 0, 0, 0);
        issue(CMD_LOAD, 0, 29, 2, 2100);
        issue(CMD_YEARS, 7, 0, 0, 0);
        issue(CMD_LOAD, 0, 10, 13, 0);
        n_directed = n_sent;

        while (n_sent - n_directed < ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                random_valid_load();
                repeat ($urandom_range(1, 6)) random_add();
            end else begin
                issue(cmd_t'(2'($urandom_range(0, 3))), int'($urandom_range(0, 2047)),
                      $urandom_range(0, 31), $urandom_range(0, 15),
                      $urandom_range(0, 65535));
                repeat ($urandom_range(0, 2)) random_add();
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Covered %0d items: %0d loads, %0d day, %0d month and %0d year adds.",
                 n_sent, cmd_seen[CMD_LOAD], cmd_seen[CMD_DAYS], cmd_seen[CMD_MONTHS],
                 cmd_seen[CMD_YEARS]);
        $display("Compared %0d result items against the predicted calendar.", checked_count);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d result items still pending.", outstanding);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
